// ===== src/dar_pkg.sv =====
// ----------------------------------------------------------------------------
// dar_pkg: shared types and constants of the DNS A-record responder
// Host name tables, header patch values, answer layout and the word types
// that move between the core, the match lanes and the answer cells.
// ----------------------------------------------------------------------------
`default_nettype none

package dar_pkg;

   // Header offsets that get patched and their replacement bytes
   localparam logic [9:0] OFS_FLAGS_HI   = 10'd2;
   localparam logic [9:0] OFS_FLAGS_LO   = 10'd3;
   localparam logic [9:0] OFS_ANCOUNT_LO = 10'd7;
   localparam logic [9:0] OFS_NAME_START = 10'd12;
   localparam logic [7:0] FLAGS_HI_BYTE   = 8'h81;
   localparam logic [7:0] FLAGS_LO_BYTE   = 8'h80;
   localparam logic [7:0] ANCOUNT_LO_BYTE = 8'h01;

   // Offset counter cap and name position cap
   localparam int unsigned OFFSET_CAP = 1023;
   localparam logic [5:0]  POS_MAX    = 6'd63;

   localparam logic [7:0] CHAR_DOT = 8'h2E;

   // Fixed host names, lowercase, padded with zeros
   localparam int unsigned FIXED_NAMES = 3;
   localparam int unsigned NAME_CHARS  = 12;
   localparam logic [7:0] HOST_CHARS [FIXED_NAMES][NAME_CHARS] = '{
      '{8'h6A, 8'h65, 8'h6E, 8'h6B, 8'h69, 8'h6E, 8'h73, 8'h2E, 8'h77, 8'h65, 8'h73, 8'h74},
      '{8'h70, 8'h72, 8'h6F, 8'h78, 8'h6D, 8'h6F, 8'h78, 8'h2E, 8'h77, 8'h65, 8'h73, 8'h74},
      '{8'h61, 8'h72, 8'h67, 8'h6F, 8'h2E, 8'h77, 8'h65, 8'h73, 8'h74, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [5:0] HOST_LEN [FIXED_NAMES] = '{6'd12, 6'd12, 6'd9};

   // Register map and reset values
   localparam int unsigned NUM_REGS = 4;
   typedef enum logic [2:0] {
      REG_FALLBACK = 3'd0,
      REG_ENTRY0   = 3'd1,
      REG_ENTRY1   = 3'd2,
      REG_ENTRY2   = 3'd3
   } reg_index_type;
   localparam logic [31:0] REG_RESET [NUM_REGS] = '{
      32'hC0A8_0164, 32'hC0A8_0114, 32'hC0A8_641F, 32'hC0A8_0101
   };

   // Answer record layout
   localparam int unsigned ANSWER_BYTES = 16;
   localparam logic [7:0] ANS_PTR_HI  = 8'hC0;
   localparam logic [7:0] ANS_PTR_LO  = 8'h0C;
   localparam logic [7:0] ANS_TYPE_A  = 8'h01;
   localparam logic [7:0] ANS_CLASS   = 8'h01;
   localparam logic [7:0] ANS_TTL_LO  = 8'd10;
   localparam logic [7:0] ANS_RDLEN   = 8'h04;

   // One byte held in an answer cell
   typedef struct packed {
      logic       valid;
      logic       last;
      logic [7:0] data;
   } ans_word_type;

   // Per-byte control broadcast to the match lanes
   typedef struct packed {
      logic       clear;
      logic       match;
      logic       finish;
      logic [7:0] ch;
      logic [5:0] pos;
   } lane_ctrl_type;

   // Expected character of a host name at a position (zero past its end)
   function automatic logic [7:0] host_char(input logic [1:0] entry, input logic [5:0] pos);
      logic [7:0] c;
      c = 8'h00;
      if (pos < 6'(NAME_CHARS)) begin
         case (entry)
            2'd0:    c = HOST_CHARS[0][pos[3:0]];
            2'd1:    c = HOST_CHARS[1][pos[3:0]];
            2'd2:    c = HOST_CHARS[2][pos[3:0]];
            default: c = 8'h00;
         endcase
      end
      return c;
   endfunction

   // Byte of the answer record at an index
   function automatic logic [7:0] answer_byte(input logic [3:0] idx, input logic [31:0] addr);
      logic [7:0] b;
      case (idx)
         4'd0:    b = ANS_PTR_HI;
         4'd1:    b = ANS_PTR_LO;
         4'd3:    b = ANS_TYPE_A;
         4'd5:    b = ANS_CLASS;
         4'd9:    b = ANS_TTL_LO;
         4'd11:   b = ANS_RDLEN;
         4'd12:   b = addr[31:24];
         4'd13:   b = addr[23:16];
         4'd14:   b = addr[15:8];
         4'd15:   b = addr[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== src/dns_a_record_responder_core.sv =====
// ----------------------------------------------------------------------------
// dns_a_record_responder_core: DNS A-record responder
// Echoes a query with patched header bytes, parses the query name and
// appends a 16-byte A answer for the matching host entry, else the fallback.
// ----------------------------------------------------------------------------
// Usage:
//  req_*  carries the query, one byte per word, req_tlast on the final byte.
//  rsp_*  carries the reply: each query byte echoed (header bytes 2, 3 and 7
//         patched), then after the last byte a 16-byte answer, rsp_tlast on
//         its final byte.
//  csr_*  writes the four address registers; csr_ready is always high.
//         Write only while no query is in flight.
//  Each echoed byte appears on rsp in the cycle after it is taken.
//  Throughput: one query byte per cycle while rsp accepts. After the byte
//  with req_tlast, req_tready stays low while the answer chain is loaded
//  and then until the chain has drained into the output register.
//  Bytes past the packet limit are dropped but their tlast still answers.
//  When rsp stalls, the output register holds and req_tready drops in the
//  same cycle. Reset clears the parser, empties the chain and the output
//  register and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_a_record_responder_core
   import dar_pkg::*;
#(
   parameter int NUM_ENTRIES      = 3,
   parameter int MAX_PACKET_BYTES = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // query channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] query_byte
   input  wire logic        req_tlast,   // query_last
   // reply channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] reply_byte
   output logic             rsp_tlast,   // reply_last
   // register write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int unsigned LANES = (NUM_ENTRIES < int'(FIXED_NAMES)) ?
                                   NUM_ENTRIES : int'(FIXED_NAMES);
   localparam int unsigned LIMIT = (MAX_PACKET_BYTES > int'(OFFSET_CAP)) ?
                                   OFFSET_CAP : MAX_PACKET_BYTES;

   // address registers
   logic [31:0] addr_ff [NUM_REGS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(NUM_REGS); i++) begin
            addr_ff[i] <= REG_RESET[i];
         end
      end else if (csr_valid && csr_ready && csr_index <= REG_ENTRY2) begin
         addr_ff[csr_index[1:0]] <= csr_data;
      end
   end

   // parser state
   logic [9:0]   offset_ff, offset_in;
   logic [7:0]   label_ff, label_in;
   logic [5:0]   pos_ff, pos_in;
   logic         done_ff, done_in;
   logic         ans_load_ff, ans_load_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_data_ff, rsp_data_in;
   logic         rsp_last_ff, rsp_last_in;

   lane_ctrl_type lane_ctrl;
   logic [LANES-1:0] lane_matched;
   ans_word_type  chain_word [ANSWER_BYTES];
   ans_word_type  chain_load [ANSWER_BYTES];

   logic       out_free;
   logic       req_accept;
   logic       in_window;
   logic       chain_shift;
   logic [7:0] folded;
   logic [7:0] echo_byte;
   logic [31:0] answer_addr;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = out_free && !ans_load_ff && !chain_word[0].valid;
   assign req_accept  = req_tvalid && req_tready;
   assign in_window   = offset_ff < 10'(LIMIT);
   assign chain_shift = out_free && chain_word[0].valid;

   // case folding of name characters
   always_comb begin
      folded = req_tdata;
      if (req_tdata inside {[8'h41:8'h5A]}) begin
         folded = req_tdata + 8'h20;
      end
   end

   // header patching of the echo
   always_comb begin
      case (offset_ff)
         OFS_FLAGS_HI:   echo_byte = FLAGS_HI_BYTE;
         OFS_FLAGS_LO:   echo_byte = FLAGS_LO_BYTE;
         OFS_ANCOUNT_LO: echo_byte = ANCOUNT_LO_BYTE;
         default:        echo_byte = req_tdata;
      endcase
   end

   // label walk over the query name
   always_comb begin
      offset_in   = offset_ff;
      label_in    = label_ff;
      pos_in      = pos_ff;
      done_in     = done_ff;
      ans_load_in = 1'b0;
      lane_ctrl   = '0;
      lane_ctrl.pos = pos_ff;
      lane_ctrl.ch  = folded;
      if (ans_load_ff) begin
         offset_in       = '0;
         label_in        = '0;
         pos_in          = '0;
         done_in         = 1'b0;
         lane_ctrl.clear = 1'b1;
      end else if (req_accept) begin
         ans_load_in = req_tlast;
         if (in_window) begin
            offset_in = offset_ff + 10'd1;
            if (offset_ff >= OFS_NAME_START && !done_ff) begin
               if (label_ff == 8'd0) begin
                  if (req_tdata == 8'd0) begin
                     done_in          = 1'b1;
                     lane_ctrl.finish = 1'b1;
                  end else begin
                     label_in = req_tdata;
                     if (offset_ff != OFS_NAME_START) begin
                        lane_ctrl.match = 1'b1;
                        lane_ctrl.ch    = CHAR_DOT;
                     end
                  end
               end else begin
                  lane_ctrl.match = 1'b1;
                  label_in        = label_ff - 8'd1;
               end
               if (lane_ctrl.match && pos_ff < POS_MAX) begin
                  pos_in = pos_ff + 6'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         label_ff    <= '0;
         pos_ff      <= '0;
         done_ff     <= 1'b0;
         ans_load_ff <= 1'b0;
      end else begin
         offset_ff   <= offset_in;
         label_ff    <= label_in;
         pos_ff      <= pos_in;
         done_ff     <= done_in;
         ans_load_ff <= ans_load_in;
      end
   end

   // one compare lane per host entry
   for (genvar k = 0; k < int'(LANES); k++) begin : g_lane
      dar_match_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (lane_ctrl),
         .expected_char (host_char(2'(k), pos_ff)),
         .name_len      (HOST_LEN[k]),
         .matched       (lane_matched[k])
      );
   end

   // lowest matching entry wins, else the fallback address
   always_comb begin
      answer_addr = addr_ff[REG_FALLBACK[1:0]];
      for (int k = int'(LANES) - 1; k >= 0; k--) begin
         if (lane_matched[k]) begin
            answer_addr = addr_ff[2'(k + 1)];
         end
      end
   end

   // answer chain: loaded in parallel, drained from cell 0
   for (genvar i = 0; i < int'(ANSWER_BYTES); i++) begin : g_cell
      assign chain_load[i].valid = 1'b1;
      assign chain_load[i].last  = (i == int'(ANSWER_BYTES) - 1);
      assign chain_load[i].data  = answer_byte(4'(i), answer_addr);

      dar_answer_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (ans_load_ff),
         .shift     (chain_shift),
         .load_word (chain_load[i]),
         .next_word ((i == int'(ANSWER_BYTES) - 1) ? ans_word_type'('0) :
                                                     chain_word[(i + 1) % ANSWER_BYTES]),
         .word      (chain_word[i])
      );
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (req_accept && in_window) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = echo_byte;
         rsp_last_in  = 1'b0;
      end else if (chain_shift) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = chain_word[0].data;
         rsp_last_in  = chain_word[0].last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== src/dar_match_lane.sv =====
// ----------------------------------------------------------------------------
// dar_match_lane: name compare lane for one host table entry
// Tracks whether the parsed name still agrees with this entry and whether
// it matched the whole name once the terminating label was seen.
// ----------------------------------------------------------------------------
`default_nettype none

module dar_match_lane
   import dar_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lane_ctrl_type ctrl,
   input  wire logic [7:0]    expected_char,
   input  wire logic [5:0]    name_len,
   output logic               matched
);

   logic still_ff, still_in;
   logic matched_ff, matched_in;

   // compare one name character or close out the name
   always_comb begin
      still_in   = still_ff;
      matched_in = matched_ff;
      if (ctrl.clear) begin
         still_in   = 1'b1;
         matched_in = 1'b0;
      end else if (ctrl.match) begin
         if (ctrl.pos >= name_len || ctrl.ch != expected_char) begin
            still_in = 1'b0;
         end
      end else if (ctrl.finish) begin
         matched_in = still_ff && (name_len == ctrl.pos);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         still_ff   <= 1'b1;
         matched_ff <= 1'b0;
      end else begin
         still_ff   <= still_in;
         matched_ff <= matched_in;
      end
   end

   assign matched = matched_ff;

endmodule

`default_nettype wire

// ===== src/dar_answer_cell.sv =====
// ----------------------------------------------------------------------------
// dar_answer_cell: one byte cell of the answer shift chain
// Loads its answer byte in parallel, then passes bytes toward the output
// one place per shift.
// ----------------------------------------------------------------------------
`default_nettype none

module dar_answer_cell
   import dar_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire logic         shift,
   input  wire ans_word_type load_word,
   input  wire ans_word_type next_word,
   output ans_word_type      word
);

   ans_word_type word_ff, word_in;

   // load has priority; otherwise take the neighbor's byte on shift
   always_comb begin
      word_in = word_ff;
      if (load) begin
         word_in = load_word;
      end else if (shift) begin
         word_in = next_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign word = word_ff;

endmodule

`default_nettype wire

// ===== src/dar_checker.sv =====
// ----------------------------------------------------------------------------
// dar_checker: port-level checks of the DNS A-record responder
// Watches the query, reply and register channels of the core.
// ----------------------------------------------------------------------------
`default_nettype none

module dar_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        csr_valid,
   input wire logic        csr_ready
);

   // a stalled reply word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("reply word changed while stalled");

   // the answer is being built after a final query byte
   a_req_block: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("query taken right after its final byte");

   // two answer ends never come back to back
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !(rsp_tvalid && rsp_tlast))
      else $error("answer end repeated");

   // register port never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind dns_a_record_responder_core dar_checker u_dar_checker (.*);

`default_nettype wire
